[hdl/scrl_pkg.sv]
// shared types and constants of the screlu output layer
`default_nettype none
package scrl_pkg;

    localparam int VAL_W     = 16;
    localparam int CLAMP_W   = 15;
    localparam int BIAS_W    = 16;
    localparam int SCALE_W   = 16;
    localparam int TDIV_W    = 30;
    localparam int SUM_W     = 32;
    localparam int SCORE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 30;
    // biased score: |sum / limit| <= 2^31 plus a 16-bit bias
    localparam int S1_W      = 34;
    // scaled score magnitude stays below 2^48
    localparam int MAG_W     = 48;
    localparam int S2_W      = MAG_W + 1;

    localparam logic [CLAMP_W-1:0] CLAMP_RST = CLAMP_W'(255);
    localparam logic [BIAS_W-1:0]  BIAS_RST  = '0;
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(400);
    localparam logic [TDIV_W-1:0]  TDIV_RST  = TDIV_W'(16320);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLAMP_LIMIT,
        CFG_OUTPUT_BIAS,
        CFG_EVAL_SCALE,
        CFG_TOTAL_DIVISOR
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_ACC,
        S_DRAIN,
        S_DIV1,
        S_BIAS,
        S_MUL,
        S_START2,
        S_DIV2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] white_value;
        logic signed [VAL_W-1:0] black_value;
        logic                    stm_is_white;
        logic signed [VAL_W-1:0] weight_us;
        logic signed [VAL_W-1:0] weight_them;
    } t_in_beat;

    typedef struct packed {
        logic acc_en;
        logic div1_start;
        logic bias_en;
        logic mul_en;
        logic div2_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

[hdl/scrl_ifs.sv]
// valid/ready channel interfaces for input beats and score beats
`default_nettype none
interface scrl_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [scrl_pkg::VAL_W-1:0]    white_value;
    logic signed [scrl_pkg::VAL_W-1:0]    black_value;
    logic                                 stm_is_white;
    logic signed [scrl_pkg::VAL_W-1:0]    weight_us;
    logic signed [scrl_pkg::VAL_W-1:0]    weight_them;
    logic                                 last;

    modport source (
        output valid, white_value, black_value, stm_is_white,
        output weight_us, weight_them, last,
        input  ready
    );
    modport sink (
        input  valid, white_value, black_value, stm_is_white,
        input  weight_us, weight_them, last,
        output ready
    );
endinterface

interface scrl_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [scrl_pkg::SCORE_W-1:0]  score;

    modport source (output valid, score, input ready);
    modport sink   (input valid, score, output ready);
endinterface
`default_nettype wire

[hdl/screlu_output_layer.sv]
// top level: squared clipped relu output layer with scaled score
// throughput: one input beat per cycle while accumulating hidden indexes
// after the accept of the beat marked last, a valid score waits for the drain of
//   the 3-stage multiply-accumulate pipe and two serial divisions
// input is held off from the last beat until the score is loaded; a new beat is taken the cycle after the load
// reset: synchronous active low; sum cleared, registers to their defaults, no score held
`default_nettype none
module screlu_output_layer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [scrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [scrl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    scrl_in_if.sink                              i_in,
    scrl_out_if.source                           o_out
);
    import scrl_pkg::*;

    t_in_beat beat;
    t_dp_cmd  cmd;
    t_dp_sts  sts;

    // payload of one input beat, handed to the datapath as a bundle
    always_comb begin
        beat.white_value  = i_in.white_value;
        beat.black_value  = i_in.black_value;
        beat.stm_is_white = i_in.stm_is_white;
        beat.weight_us    = i_in.weight_us;
        beat.weight_them  = i_in.weight_them;
    end

    // sequencer: takes beats back to back until the last one, then waits for
    // the pipe to drain and walks the divide / bias / scale / divide steps;
    // the score sits in an output register until the sink takes it, and the
    // next accumulation runs meanwhile
    scrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // datapath: clamp, trunc16(w*c)*c per half in two multiplier stages,
    // 32-bit wrapping sum, then a shared serial divider for both divisions
    // (zero divisors act as one) and the 64-bit-equivalent scaling
    scrl_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beat     (beat),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_score    (o_out.score)
    );
endmodule
`default_nettype wire

[hdl/scrl_div.sv]
// radix-2 restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module scrl_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 30
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quot
);
    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DVD_W-1:0]   r_q, n_q;
    logic [DVS_W-1:0]   r_rem, n_rem;
    logic [DVS_W-1:0]   r_dvs, n_dvs;
    logic [DVS_W:0]     rem_sh;
    logic [DVS_W+1:0]   diff;
    logic               ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = ~diff[DVS_W+1];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_q   = {r_q[DVD_W-2:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[hdl/scrl_datapath.sv]
// config registers, multiply-accumulate pipe and final scaling datapath
`default_nettype none
module scrl_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [scrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [scrl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire scrl_pkg::t_in_beat              i_beat,
    input  wire scrl_pkg::t_dp_cmd               i_cmd,
    output scrl_pkg::t_dp_sts                    o_sts,
    output logic signed [scrl_pkg::SCORE_W-1:0]  o_score
);
    import scrl_pkg::*;

    logic [CLAMP_W-1:0]         r_clamp;
    logic [BIAS_W-1:0]          r_bias;
    logic [SCALE_W-1:0]         r_scale;
    logic [TDIV_W-1:0]          r_tdiv;

    logic                       r_v1, r_v2;
    logic signed [VAL_W-1:0]    r_t_us, r_t_them;
    logic [CLAMP_W-1:0]         r_c_us, r_c_them;
    logic signed [SUM_W-1:0]    r_p_us, r_p_them;
    logic signed [SUM_W-1:0]    r_sum;

    logic                       r_neg;
    logic signed [S1_W-1:0]     r_s1;
    logic signed [S2_W-1:0]     r_s2;
    logic signed [SCORE_W-1:0]  r_score;

    logic signed [VAL_W-1:0]    us_val, them_val;
    logic [CLAMP_W-1:0]         c_us, c_them;
    logic signed [2*VAL_W-1:0]  m1_us, m1_them, m2_us, m2_them;
    logic signed [S1_W+SCALE_W:0] m3;
    logic [SUM_W-1:0]           sum_mag;
    logic [MAG_W-1:0]           s2_mag;
    logic [MAG_W-1:0]           dvd;
    logic [TDIV_W-1:0]          dvs;
    logic                       div_start;
    logic [MAG_W-1:0]           quot;
    logic signed [S1_W-1:0]     bias_ext, q1_ext;
    logic                       div_done;

    function automatic logic [CLAMP_W-1:0] clamp_act(
        input logic signed [VAL_W-1:0] v,
        input logic [CLAMP_W-1:0]      lim
    );
        logic [CLAMP_W-1:0] r;
        if (v[VAL_W-1]) begin
            r = '0;
        end else if (v[CLAMP_W-1:0] > lim) begin
            r = lim;
        end else begin
            r = v[CLAMP_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        us_val   = i_beat.stm_is_white ? i_beat.white_value : i_beat.black_value;
        them_val = i_beat.stm_is_white ? i_beat.black_value : i_beat.white_value;
        c_us     = clamp_act(us_val, r_clamp);
        c_them   = clamp_act(them_val, r_clamp);
        m1_us    = i_beat.weight_us   * $signed({1'b0, c_us});
        m1_them  = i_beat.weight_them * $signed({1'b0, c_them});
        m2_us    = r_t_us   * $signed({1'b0, r_c_us});
        m2_them  = r_t_them * $signed({1'b0, r_c_them});
        m3       = r_s1 * $signed({1'b0, r_scale});
        sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        s2_mag   = r_s2[S2_W-1] ? MAG_W'(-r_s2) : MAG_W'(r_s2);
        bias_ext = S1_W'($signed(r_bias));
        q1_ext   = $signed({2'b00, quot[SUM_W-1:0]});
        div_start = i_cmd.div1_start | i_cmd.div2_start;
        if (i_cmd.div1_start) begin
            dvd = MAG_W'(sum_mag);
            dvs = (r_clamp == '0) ? TDIV_W'(1) : TDIV_W'(r_clamp);
        end else begin
            dvd = s2_mag;
            dvs = (r_tdiv == '0) ? TDIV_W'(1) : r_tdiv;
        end
    end

    scrl_div #(
        .DVD_W (MAG_W),
        .DVS_W (TDIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= CLAMP_RST;
            r_bias  <= BIAS_RST;
            r_scale <= SCALE_RST;
            r_tdiv  <= TDIV_RST;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_sum   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CLAMP_LIMIT:   r_clamp <= i_cfg_data[CLAMP_W-1:0];
                    CFG_OUTPUT_BIAS:   r_bias  <= i_cfg_data[BIAS_W-1:0];
                    CFG_EVAL_SCALE:    r_scale <= i_cfg_data[SCALE_W-1:0];
                    CFG_TOTAL_DIVISOR: r_tdiv  <= i_cfg_data[TDIV_W-1:0];
                    default:           r_tdiv  <= r_tdiv;
                endcase
            end
            r_v1 <= i_cmd.acc_en;
            r_v2 <= r_v1;
            if (i_cmd.div1_start) begin
                r_sum <= '0;
            end else if (r_v2) begin
                r_sum <= r_sum + r_p_us + r_p_them;
            end
        end
        // stage 1: clamp and first product, low half kept
        r_t_us   <= m1_us[VAL_W-1:0];
        r_t_them <= m1_them[VAL_W-1:0];
        r_c_us   <= c_us;
        r_c_them <= c_them;
        // stage 2: second product
        r_p_us   <= m2_us;
        r_p_them <= m2_them;
        if (i_cmd.div1_start) begin
            r_neg <= r_sum[SUM_W-1];
        end else if (i_cmd.div2_start) begin
            r_neg <= r_s2[S2_W-1];
        end
        if (i_cmd.bias_en) begin
            r_s1 <= r_neg ? (bias_ext - q1_ext) : (bias_ext + q1_ext);
        end
        if (i_cmd.mul_en) begin
            r_s2 <= m3[S2_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_score <= r_neg ? $signed(SCORE_W'(-quot[SCORE_W-1:0]))
                             : $signed(quot[SCORE_W-1:0]);
        end
    end

    assign o_sts.pipe_busy = r_v1 | r_v2;
    assign o_sts.div_done  = div_done;
    assign o_score         = r_score;
endmodule
`default_nettype wire

[hdl/scrl_ctrl.sv]
// sequencer for accumulation, drain, divisions and score hand-off
`default_nettype none
module scrl_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_last,
    input  wire logic               i_out_ready,
    input  wire scrl_pkg::t_dp_sts  i_sts,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    output scrl_pkg::t_dp_cmd       o_cmd
);
    import scrl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready   = 1'b1;
                o_cmd.acc_en = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.div1_start = 1'b1;
                    n_state = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    n_state = S_BIAS;
                end
            end
            S_BIAS: begin
                o_cmd.bias_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_START2;
            end
            S_START2: begin
                o_cmd.div2_start = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire
